FILE: design/rp2d_pkg.sv
// Shared types, widths and constants for the pipelined 2D point rotator.
// Used by rp2d_cell, rp2d_mul and rotate_point_2d_degrees_unit; no dependencies.
package rp2d_pkg;

  localparam int FRAC_BITS    = 8;                 // fractional bits of the results
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int COS_FRAC     = 30;                // cos/sin are Q30
  localparam int ANG_FRAC     = 16;                // angle in degrees, Q16
  localparam int CS_W         = 32;                // cos/sin datapath width
  localparam int Z_W          = 25;                // residual angle width
  localparam int PT_W         = 8;                 // input coordinate width
  localparam int PROD_W       = PT_W + 1 + CS_W;   // sign-adjusted coord times cos/sin
  localparam int ACC_W        = PROD_W + 1;
  localparam int OUT_W        = 17;
  localparam int RND_SHIFT    = COS_FRAC - FRAC_BITS;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;

  localparam logic signed [CS_W-1:0]  GAIN_Q30 = CS_W'(652032874);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (RND_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);
  localparam logic signed [PT_W:0]    ANG_HI   = (PT_W + 1)'(90);
  localparam logic signed [PT_W:0]    ANG_HALF = (PT_W + 1)'(180);
  localparam logic signed [Z_W-1:0]   Z_LIMIT  = Z_W'(90 * (2 ** ANG_FRAC));

  // Payload carried from cell to cell
  typedef struct packed {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
    logic signed [Z_W-1:0]  z;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   flip;
  } rp2d_cell_t;

  // atan(2^-k) in degrees, Q16
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] k);
    logic signed [Z_W-1:0] v;
    case (k)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/rp2d_cell.sv
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on rp2d_pkg for the payload struct and widths.
module rp2d_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [rp2d_pkg::STEP_W-1:0] step,
  input  logic signed [rp2d_pkg::Z_W-1:0] atan,
  input  logic                        din_vld,
  input  rp2d_pkg::rp2d_cell_t        din,
  output logic                        dout_vld,
  output rp2d_pkg::rp2d_cell_t        dout
);

  rp2d_pkg::rp2d_cell_t dout_next;
  logic signed [rp2d_pkg::CS_W-1:0] dc;
  logic signed [rp2d_pkg::CS_W-1:0] ds;

  always_comb begin
    dc = din.s >>> step;
    ds = din.c >>> step;
    dout_next = din;
    // zero or positive residual rotates counterclockwise
    if (!din.z[rp2d_pkg::Z_W-1]) begin
      dout_next.c = din.c - dc;
      dout_next.s = din.s + ds;
      dout_next.z = din.z - atan;
    end else begin
      dout_next.c = din.c + dc;
      dout_next.s = din.s - ds;
      dout_next.z = din.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_vld <= 1'b0;
    end else if (en) begin
      dout_vld <= din_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: design/rp2d_mul.sv
// Final stages: apply the half-turn flip, multiply the point by cos/sin,
// sum, round to FRAC_BITS and saturate. Depends on rp2d_pkg.
module rp2d_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              din_vld,
  input  rp2d_pkg::rp2d_cell_t              din,
  output logic                              dout_vld,
  output logic signed [rp2d_pkg::OUT_W-1:0] x_out,
  output logic signed [rp2d_pkg::OUT_W-1:0] y_out
);

  logic signed [rp2d_pkg::PT_W:0]     pxf;
  logic signed [rp2d_pkg::PT_W:0]     pyf;
  logic                               prod_vld;
  logic signed [rp2d_pkg::PROD_W-1:0] prod_xc;
  logic signed [rp2d_pkg::PROD_W-1:0] prod_ys;
  logic signed [rp2d_pkg::PROD_W-1:0] prod_xs;
  logic signed [rp2d_pkg::PROD_W-1:0] prod_yc;
  logic signed [rp2d_pkg::ACC_W-1:0]  acc_x;
  logic signed [rp2d_pkg::ACC_W-1:0]  acc_y;
  logic signed [rp2d_pkg::ACC_W-1:0]  rnd_x;
  logic signed [rp2d_pkg::ACC_W-1:0]  rnd_y;
  logic signed [rp2d_pkg::OUT_W-1:0]  x_next;
  logic signed [rp2d_pkg::OUT_W-1:0]  y_next;

  // negating the coordinates is the same as negating cos and sin
  always_comb begin
    pxf = (rp2d_pkg::PT_W + 1)'(din.px);
    pyf = (rp2d_pkg::PT_W + 1)'(din.py);
    if (din.flip) begin
      pxf = -pxf;
      pyf = -pyf;
    end
  end

  always_comb begin
    acc_x = rp2d_pkg::ACC_W'(prod_xc) - rp2d_pkg::ACC_W'(prod_ys);
    acc_y = rp2d_pkg::ACC_W'(prod_xs) + rp2d_pkg::ACC_W'(prod_yc);
    rnd_x = (acc_x + rp2d_pkg::RND_HALF) >>> rp2d_pkg::RND_SHIFT;
    rnd_y = (acc_y + rp2d_pkg::RND_HALF) >>> rp2d_pkg::RND_SHIFT;
    if (rnd_x > rp2d_pkg::SAT_HI) begin
      x_next = rp2d_pkg::SAT_HI[rp2d_pkg::OUT_W-1:0];
    end else if (rnd_x < rp2d_pkg::SAT_LO) begin
      x_next = rp2d_pkg::SAT_LO[rp2d_pkg::OUT_W-1:0];
    end else begin
      x_next = rnd_x[rp2d_pkg::OUT_W-1:0];
    end
    if (rnd_y > rp2d_pkg::SAT_HI) begin
      y_next = rp2d_pkg::SAT_HI[rp2d_pkg::OUT_W-1:0];
    end else if (rnd_y < rp2d_pkg::SAT_LO) begin
      y_next = rp2d_pkg::SAT_LO[rp2d_pkg::OUT_W-1:0];
    end else begin
      y_next = rnd_y[rp2d_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      dout_vld <= 1'b0;
    end else if (en) begin
      prod_vld <= din_vld;
      dout_vld <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_xc <= pxf * din.c;
      prod_ys <= pyf * din.s;
      prod_xs <= pxf * din.s;
      prod_yc <= pyf * din.c;
      x_out   <= x_next;
      y_out   <= y_next;
    end
  end

endmodule

FILE: design/rotate_point_2d_degrees_unit.sv
// Top level of the 2D point rotator: angle fold, a chain of CORDIC cells,
// then multiply/round. Depends on rp2d_pkg, rp2d_cell and rp2d_mul.
//
//   channel   dir  tdata fields (low bit up)            notes
//   s_axis    in   x_in[7:0] y_in[15:8] angle[23:16]    one point per transaction
//   m_axis    out  x_out[16:0] y_out[33:17] pad zeros   one result per point
//
// Fully pipelined: one point per cycle unless a result held on m_tready stalls it;
// 20 CORDIC cells, one multiply stage, one round/saturate stage that doubles as output register.
// Reset clears the valid bits of every stage; data registers are not reset.
// A result that waits on m_tready freezes the whole chain; while the output
// moves, a new point is taken in the same cycle.
module rotate_point_2d_degrees_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rp2d_pkg::IN_TDATA_W-1:0]     s_tdata,  // x_in, y_in, angle_deg
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rp2d_pkg::OUT_TDATA_W-1:0]    m_tdata   // x_out, y_out, zero pad
);

  logic                              en;
  logic signed [rp2d_pkg::PT_W-1:0]  ang;
  logic signed [rp2d_pkg::PT_W:0]    ang_wide;
  logic signed [rp2d_pkg::PT_W:0]    ang_fold;
  logic                              flip;
  rp2d_pkg::rp2d_cell_t              head;
  logic                              cell_vld [rp2d_pkg::CORDIC_STEPS+1];
  rp2d_pkg::rp2d_cell_t              cell_dat [rp2d_pkg::CORDIC_STEPS+1];
  logic signed [rp2d_pkg::OUT_W-1:0] x_out;
  logic signed [rp2d_pkg::OUT_W-1:0] y_out;

  // advance everything unless a result is held at the output
  assign en       = !(m_tvalid && !m_tready);
  assign s_tready = en;

  // fold the angle into [-90, 90] by a half turn
  always_comb begin
    ang      = s_tdata[3*rp2d_pkg::PT_W-1:2*rp2d_pkg::PT_W];
    ang_wide = (rp2d_pkg::PT_W + 1)'(ang);
    ang_fold = ang_wide;
    flip     = 1'b0;
    if (ang_wide > rp2d_pkg::ANG_HI) begin
      ang_fold = ang_wide - rp2d_pkg::ANG_HALF;
      flip     = 1'b1;
    end else if (ang_wide < -rp2d_pkg::ANG_HI) begin
      ang_fold = ang_wide + rp2d_pkg::ANG_HALF;
      flip     = 1'b1;
    end
    head.c    = rp2d_pkg::GAIN_Q30;
    head.s    = '0;
    head.z    = rp2d_pkg::Z_W'(ang_fold) <<< rp2d_pkg::ANG_FRAC;
    head.px   = s_tdata[rp2d_pkg::PT_W-1:0];
    head.py   = s_tdata[2*rp2d_pkg::PT_W-1:rp2d_pkg::PT_W];
    head.flip = flip;
  end

  assign cell_vld[0] = s_tvalid;
  assign cell_dat[0] = head;

  for (genvar g = 0; g < rp2d_pkg::CORDIC_STEPS; g++) begin : g_cell
    rp2d_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .step     (rp2d_pkg::STEP_W'(g)),
      .atan     (rp2d_pkg::atan_q16(rp2d_pkg::STEP_W'(g))),
      .din_vld  (cell_vld[g]),
      .din      (cell_dat[g]),
      .dout_vld (cell_vld[g+1]),
      .dout     (cell_dat[g+1])
    );
  end

  rp2d_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .din_vld  (cell_vld[rp2d_pkg::CORDIC_STEPS]),
    .din      (cell_dat[rp2d_pkg::CORDIC_STEPS]),
    .dout_vld (m_tvalid),
    .x_out    (x_out),
    .y_out    (y_out)
  );

  assign m_tdata = {
    (rp2d_pkg::OUT_TDATA_W - 2*rp2d_pkg::OUT_W)'(0), y_out, x_out
  };

`ifndef NO_ASSERTIONS
  // an accepted point shows up in the first cell next cycle
  a_head_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cell_vld[1])
    else $error("accepted point did not enter the first cell");

  // the folded angle never leaves a quarter turn
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    cell_vld[1] |-> (cell_dat[1].z + rp2d_pkg::atan_q16('0) <= rp2d_pkg::Z_LIMIT + 
    rp2d_pkg::atan_q16('0)) && (cell_dat[1].z >= -rp2d_pkg::Z_LIMIT))
    else $error("folded angle out of range");

  // a held result freezes the last cell
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(cell_vld[rp2d_pkg::CORDIC_STEPS]) &&
    $stable(cell_dat[rp2d_pkg::CORDIC_STEPS]))
    else $error("pipeline moved while output stalled");
`endif

endmodule
